>>> sv/uqsd_pkg.sv
`timescale 1ns / 1ps
package uqsd_pkg;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = 2;

  typedef enum logic [2:0] {
    KIND_BASE_BYTE  = 3'd0,
    KIND_KEY_BYTE   = 3'd1,
    KIND_VALUE_BYTE = 3'd2,
    KIND_BASE_END   = 3'd3,
    KIND_KEY_END    = 3'd4,
    KIND_VALUE_END  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_BASE  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2,
    ESC_SKIP = 2'd3
  } esc_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       bad;
  } res_t;

  // Results caused by one accepted byte, slot 0 first.
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    res_t [MaxResults-1:0]    res;
  } batch_t;

endpackage

>>> sv/uqsd_parser.sv
`timescale 1ns / 1ps
module uqsd_parser
  import uqsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_url,
  output batch_t     batch
);

  localparam logic [7:0] ChQuery   = 8'h3F;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChPercent = 8'h25;

  phase_t     phase_r, phase_nxt, ph1;
  esc_t       esc_r, esc_nxt, es1;
  logic [3:0] hd_r, hd_nxt, hd1;
  logic       bad_r, bad_nxt;

  logic       hex_ok;
  logic [3:0] hex_v;
  logic       se, set_bad, bp1, two_ends;
  kind_t      sk, fk, ek0;
  logic [7:0] sb;
  res_t       rs, e0, e1;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_v = 4'(in_byte - 8'h30);
    end else if (in_byte inside {[8'h61:8'h66]}) begin
      hex_v = 4'(in_byte - 8'h57);
    end else if (in_byte inside {[8'h41:8'h46]}) begin
      hex_v = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Byte step: delimiters first, then percent decoding inside a field.
  always_comb begin
    ph1     = phase_r;
    es1     = esc_r;
    hd1     = hd_r;
    set_bad = 1'b0;
    se      = 1'b0;
    sk      = KIND_BASE_BYTE;
    sb      = in_byte;
    fk      = (phase_r == PH_KEY) ? KIND_KEY_BYTE : KIND_VALUE_BYTE;
    if (phase_r == PH_BASE) begin
      se = 1'b1;
      if (in_byte == ChQuery) begin
        sk  = KIND_BASE_END;
        sb  = 8'd0;
        ph1 = PH_KEY;
        es1 = ESC_IDLE;
      end
    end else if (phase_r == PH_KEY && in_byte == ChEquals) begin
      se  = 1'b1;
      sk  = KIND_KEY_END;
      sb  = 8'd0;
      ph1 = PH_VALUE;
      es1 = ESC_IDLE;
    end else if (phase_r != PH_KEY && in_byte == ChAmp) begin
      se  = 1'b1;
      sk  = KIND_VALUE_END;
      sb  = 8'd0;
      ph1 = PH_KEY;
      es1 = ESC_IDLE;
    end else begin
      case (esc_r)
        ESC_IDLE: begin
          if (in_byte == ChPercent) begin
            es1 = ESC_HIGH;
          end else begin
            se = 1'b1;
            sk = fk;
          end
        end
        ESC_HIGH: begin
          if (hex_ok) begin
            hd1 = hex_v;
            es1 = ESC_LOW;
          end else begin
            es1 = ESC_SKIP;
          end
        end
        ESC_LOW: begin
          if (hex_ok) begin
            se = 1'b1;
            sk = fk;
            sb = {hd_r, hex_v};
          end else begin
            set_bad = 1'b1;
          end
          es1 = ESC_IDLE;
        end
        default: begin
          set_bad = 1'b1;
          es1     = ESC_IDLE;
        end
      endcase
    end
  end

  // Batch and next state: at end of URL, also close whatever is open after the byte step.
  always_comb begin
    bp1      = se ? 1'b0 : (bad_r | set_bad);
    two_ends = (ph1 == PH_KEY);
    case (ph1)
      PH_BASE: ek0 = KIND_BASE_END;
      PH_KEY:  ek0 = KIND_KEY_END;
      default: ek0 = KIND_VALUE_END;
    endcase
    rs = '{kind: sk, data: sb, bad: bad_r};
    e0 = '{kind: ek0, data: 8'd0, bad: bp1};
    e1 = '{kind: KIND_VALUE_END, data: 8'd0, bad: 1'b0};
    if (se) begin
      batch.res[0] = rs;
      batch.res[1] = e0;
      batch.res[2] = e1;
    end else begin
      batch.res[0] = e0;
      batch.res[1] = e1;
      batch.res[2] = e1;
    end
    batch.cnt = CntW'(se) +
                (in_end_of_url ? (two_ends ? CntW'(2) : CntW'(1)) : CntW'(0));
    if (in_end_of_url) begin
      phase_nxt = PH_BASE;
      esc_nxt   = ESC_IDLE;
      hd_nxt    = 4'd0;
      bad_nxt   = 1'b0;
    end else begin
      phase_nxt = ph1;
      esc_nxt   = es1;
      hd_nxt    = hd1;
      bad_nxt   = bp1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BASE;
      esc_r   <= ESC_IDLE;
      hd_r    <= 4'd0;
      bad_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      hd_r    <= hd_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

>>> sv/uqsd_out_buf.sv
`timescale 1ns / 1ps
module uqsd_out_buf
  import uqsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  batch_t     batch,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       head,
  output logic       head_last
);

  res_t [MaxResults-1:0] ent_r;
  logic [CntW-1:0]       cnt_r;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign head      = ent_r[0];
  assign head_last = (cnt_r == CntW'(1));
  // Take a new batch when the buffer is empty or its final result leaves now.
  assign room      = (cnt_r == '0) || (head_last && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= batch.res;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

endmodule

>>> sv/url_query_splitter_decoder_core.sv
`timescale 1ns / 1ps
// The first result of a byte is offered in the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_ready is high; a byte yielding several results holds the input until its
// final result leaves, the output buffer draining one result per cycle.
// Reset: rst_n synchronous, active low; parser returns to the base part and
// the result buffer empties.
module url_query_splitter_decoder_core
  import uqsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_url,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_bad_escape,
  output logic       out_last
);

  batch_t batch;
  res_t   head;
  logic   adv;

  assign adv = in_valid && in_ready;

  uqsd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_byte       (in_byte),
    .in_end_of_url (in_end_of_url),
    .batch         (batch)
  );

  uqsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .batch     (batch),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .head_last (out_last)
  );

  assign out_kind       = head.kind;
  assign out_byte       = head.data;
  assign out_bad_escape = head.bad;

`ifndef SYNTHESIS
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_url |=> out_valid)
    else $error("end of URL transfer produced no result");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BASE_END || out_kind == KIND_KEY_END ||
                  out_kind == KIND_VALUE_END) |-> out_byte == 8'd0)
    else $error("end marker carries nonzero byte");

  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || (out_last && out_ready))
    else $error("input taken while results still pending");
`endif

endmodule
